### rtl/grc_pkg.sv
// Shared constants and tables of the grid ray caster.
`timescale 1ns / 1ps
`default_nettype none
package grc_pkg;

    localparam int GRID_DIM_DEF   = 64;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int COORD_W = 6;   // width of cell coordinate fields
    localparam int DIR_W   = 18;  // signed Q1.16 direction component
    localparam int Q16_W   = 17;  // unsigned 0..65536

    localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [1:0] REG_VIEWER_X = 2'd0;
    localparam logic [1:0] REG_VIEWER_Y = 2'd1;
    localparam logic [1:0] REG_COLS     = 2'd2;
    localparam logic [1:0] REG_ROWS     = 2'd3;

    // Arctangent of 2^-i, 2^32 units per turn.
    function automatic logic [31:0] atan_units(input logic [3:0] i);
        case (i)
            4'd0:    atan_units = 32'h20000000;
            4'd1:    atan_units = 32'h12E4051E;
            4'd2:    atan_units = 32'h09FB385B;
            4'd3:    atan_units = 32'h051111D4;
            4'd4:    atan_units = 32'h028B0D43;
            4'd5:    atan_units = 32'h0145D7E1;
            4'd6:    atan_units = 32'h00A2F61E;
            4'd7:    atan_units = 32'h00517C55;
            4'd8:    atan_units = 32'h0028BE53;
            4'd9:    atan_units = 32'h00145F2F;
            4'd10:   atan_units = 32'h000A2F98;
            4'd11:   atan_units = 32'h000517CC;
            4'd12:   atan_units = 32'h00028BE6;
            4'd13:   atan_units = 32'h000145F3;
            4'd14:   atan_units = 32'h0000A2FA;
            4'd15:   atan_units = 32'h0000517D;
            default: atan_units = 32'h0;
        endcase
    endfunction

endpackage
`default_nettype wire

### rtl/grc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### rtl/grc_cordic.sv
// Iterative rotation-mode CORDIC: one rotation per cycle, 16 rotations.
`timescale 1ns / 1ps
`default_nettype none
module grc_cordic (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [29:0]                i_phase,
    output logic                            o_done,
    output logic [grc_pkg::Q16_W-1:0]       o_cos,
    output logic [grc_pkg::Q16_W-1:0]       o_sin
);

    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [32:0] r_z;
    logic [3:0]         r_iter;
    logic               r_run;
    logic               r_done;
    logic signed [33:0] n_xs;
    logic signed [33:0] n_ys;
    logic signed [32:0] n_atan;

    // Divide by 2^sh, truncating toward zero.
    function automatic logic signed [33:0] tdiv(input logic signed [33:0] v,
                                                input logic [3:0] sh);
        logic signed [33:0] q;
        logic [33:0]        m;
        q = v >>> sh;
        m = ~({34{1'b1}} << sh);
        tdiv = q + (((v[33]) && ((34'(unsigned'(v)) & m) != 34'd0)) ? 34'sd1 : 34'sd0);
    endfunction

    // Clamp at 0, round Q1.30 to Q1.16, clamp at 1.0.
    function automatic logic [grc_pkg::Q16_W-1:0] to_q16(input logic signed [33:0] v);
        logic signed [34:0] t;
        t = (35'(v) + 35'sd8192) >>> 14;
        if (v < 0) begin
            to_q16 = '0;
        end else if (t > 35'sd65536) begin
            to_q16 = 17'd65536;
        end else begin
            to_q16 = t[16:0];
        end
    endfunction

    assign n_xs   = tdiv(r_x, r_iter);
    assign n_ys   = tdiv(r_y, r_iter);
    assign n_atan = signed'({1'b0, grc_pkg::atan_units(r_iter)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_iter <= '0;
                if (i_phase == '0) begin
                    // exact (1, 0) on an axis
                    r_x    <= 34'sd1073741824;
                    r_y    <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_x   <= signed'(grc_pkg::CORDIC_GAIN);
                    r_y   <= '0;
                    r_z   <= signed'({3'b000, i_phase});
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                if (r_z >= 0) begin
                    r_x <= r_x - n_ys;
                    r_y <= r_y + n_xs;
                    r_z <= r_z - n_atan;
                end else begin
                    r_x <= r_x + n_ys;
                    r_y <= r_y - n_xs;
                    r_z <= r_z + n_atan;
                end
                r_iter <= r_iter + 4'd1;
                if (r_iter == 4'd15) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = to_q16(r_x);
    assign o_sin  = to_q16(r_y);

endmodule
`default_nettype wire

### rtl/grc_div.sv
// Bit-serial restoring divider computing floor(2^32 / divisor), saturating.
`timescale 1ns / 1ps
`default_nettype none
module grc_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [grc_pkg::Q16_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [31:0]                    o_quot
);

    logic [grc_pkg::Q16_W-1:0] r_dvs;
    logic [grc_pkg::Q16_W:0]   r_rem;
    logic [31:0]               r_quot;
    logic [5:0]                r_cnt;
    logic                      r_run;
    logic                      r_done;
    logic [grc_pkg::Q16_W:0]   n_rem_sh;
    logic                      n_ge;

    // dividend is a single one at bit 32
    assign n_rem_sh = {r_rem[grc_pkg::Q16_W-1:0], (r_cnt == 6'd32)};
    assign n_ge     = n_rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_divisor <= 17'd1) begin
                    // quotient would not fit: saturate
                    r_quot <= grc_pkg::SAT32;
                    r_done <= 1'b1;
                end else begin
                    r_dvs  <= i_divisor;
                    r_rem  <= '0;
                    r_quot <= '0;
                    r_cnt  <= 6'd32;
                    r_run  <= 1'b1;
                end
            end else if (r_run) begin
                r_rem  <= n_ge ? n_rem_sh - {1'b0, r_dvs} : n_rem_sh;
                r_quot <= {r_quot[30:0], n_ge};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

### rtl/grid_ray_cast_dda.sv
// Top level of the grid ray caster: map store, sequencer and cell walker.
`timescale 1ns / 1ps
`default_nettype none
// Grid ray caster. A write transaction (operation 0) stores one cell of the
// GRID_DIM x GRID_DIM map and returns nothing. A cast transaction
// (operation 1) returns exactly one result: the block turns the angle into a
// direction with a 16-rotation CORDIC, derives both per-axis step lengths on
// one bit-serial divider, forms both first side distances on one shared
// multiplier, then walks the map cell by cell (step, then registered map
// read), and forms the wall offset on the same multiplier. A cast crosses at
// most grid_columns + grid_rows cells. A viewer cell outside the used map
// returns a miss without a walk. The input side stalls until the cast has
// moved its result into the output register; a result there may wait while
// the next transaction is taken. Load the map and the registers before
// casting; the map has no reset and reads of unwritten cells are
// meaningless. Configuration sits on an APB-style port, one register per word.
module grid_ray_cast_dda #(
    parameter int GRID_DIM   = grc_pkg::GRID_DIM_DEF,
    parameter int ANGLE_BITS = grc_pkg::ANGLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_operation,
    input  wire logic [5:0]  i_cell_col,
    input  wire logic [5:0]  i_cell_row,
    input  wire logic [7:0]  i_cell_kind,
    input  wire logic [15:0] i_angle,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_hit,
    output logic             o_hit_side,
    output logic [7:0]       o_wall_kind,
    output logic [5:0]       o_hit_col,
    output logic [5:0]       o_hit_row,
    output logic [31:0]      o_perp_distance,
    output logic [15:0]      o_wall_offset
);

    localparam int AW = $clog2(GRID_DIM * GRID_DIM);
    localparam int MW = $clog2(GRID_DIM + 1) + 1;      // signed cell coordinate
    localparam int SW = 34 + $clog2(GRID_DIM + 2);     // side distance accumulator
    localparam int DW = grc_pkg::DIR_W;
    localparam int CW = grc_pkg::COORD_W;
    localparam logic [15:0] ANG_MASK = (ANGLE_BITS >= 16) ? 16'hFFFF :
        16'(~((32'd1 << (16 - ANGLE_BITS)) - 32'd1));

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_CORDIC = 10'b00_0000_0010,
        S_DIVX   = 10'b00_0000_0100,
        S_DIVY   = 10'b00_0000_1000,
        S_MULX   = 10'b00_0001_0000,
        S_MULY   = 10'b00_0010_0000,
        S_STEP   = 10'b00_0100_0000,
        S_READ   = 10'b00_1000_0000,
        S_OFFS   = 10'b01_0000_0000,
        S_FINISH = 10'b10_0000_0000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [21:0] r_viewer_x;
    logic [21:0] r_viewer_y;
    logic [6:0]  r_grid_cols;
    logic [6:0]  r_grid_rows;

    // cast working registers
    logic [1:0]           r_quad;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic [31:0]          r_lx;
    logic [31:0]          r_ly;
    logic [SW-1:0]        r_sx;
    logic [SW-1:0]        r_sy;
    logic signed [MW-1:0] r_mx;
    logic signed [MW-1:0] r_my;
    logic signed [MW-1:0] r_cols;
    logic signed [MW-1:0] r_rows;
    logic [CW-1:0]        r_last_x;
    logic [CW-1:0]        r_last_y;
    logic [31:0]          r_perp;
    logic                 r_side;
    logic                 r_hit;
    logic [7:0]           r_wk;
    logic [15:0]          r_offs;

    // output register
    logic        r_out_valid;
    logic        r_out_hit;
    logic        r_out_side;
    logic [7:0]  r_out_wk;
    logic [5:0]  r_out_col;
    logic [5:0]  r_out_row;
    logic [31:0] r_out_perp;
    logic [15:0] r_out_offs;

    logic                       n_accept;
    logic                       n_cfg_wr;
    logic [15:0]                n_ang;
    logic [31:0]                n_cols_c;
    logic [31:0]                n_rows_c;
    logic                       n_inside;
    logic                       n_cordic_start;
    logic                       n_cordic_done;
    logic [grc_pkg::Q16_W-1:0]  n_cos;
    logic [grc_pkg::Q16_W-1:0]  n_sin;
    logic signed [DW-1:0]       n_dx;
    logic signed [DW-1:0]       n_dy;
    logic                       n_div_start;
    logic [grc_pkg::Q16_W-1:0]  n_div_in;
    logic                       n_div_done;
    logic [31:0]                n_div_q;
    logic signed [33:0]         n_mul_a;
    logic signed [DW-1:0]       n_mul_b;
    logic signed [51:0]         n_prod;
    logic [16:0]                n_d0;
    logic                       n_take_x;
    logic signed [MW-1:0]       n_mx;
    logic signed [MW-1:0]       n_my;
    logic                       n_out_map;
    logic [AW-1:0]              n_rd_addr;
    logic                       n_wr_en;
    logic [AW-1:0]              n_wr_addr;
    logic [7:0]                 n_rd_data;
    logic                       n_load_out;

    function automatic logic [grc_pkg::Q16_W-1:0] mag(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] a;
        a = (v < 0) ? -v : v;
        mag = a[grc_pkg::Q16_W-1:0];
    endfunction

    assign n_accept = i_in_valid && !o_in_stall;
    assign n_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign n_ang    = i_angle & ANG_MASK;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viewer_x  <= '0;
            r_viewer_y  <= '0;
            r_grid_cols <= 7'd64;
            r_grid_rows <= 7'd64;
        end else if (n_cfg_wr) begin
            case (paddr[3:2])
                grc_pkg::REG_VIEWER_X: r_viewer_x  <= pwdata[21:0];
                grc_pkg::REG_VIEWER_Y: r_viewer_y  <= pwdata[21:0];
                grc_pkg::REG_COLS:     r_grid_cols <= pwdata[6:0];
                grc_pkg::REG_ROWS:     r_grid_rows <= pwdata[6:0];
                default:               ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            grc_pkg::REG_VIEWER_X: prdata = {10'd0, r_viewer_x};
            grc_pkg::REG_VIEWER_Y: prdata = {10'd0, r_viewer_y};
            grc_pkg::REG_COLS:     prdata = {25'd0, r_grid_cols};
            grc_pkg::REG_ROWS:     prdata = {25'd0, r_grid_rows};
            default:               prdata = '0;
        endcase
    end

    // clamp the used map size to 1..GRID_DIM
    always_comb begin
        n_cols_c = 32'(r_grid_cols);
        n_rows_c = 32'(r_grid_rows);
        if (n_cols_c == 32'd0) begin
            n_cols_c = 32'd1;
        end else if (n_cols_c > 32'(GRID_DIM)) begin
            n_cols_c = 32'(GRID_DIM);
        end
        if (n_rows_c == 32'd0) begin
            n_rows_c = 32'd1;
        end else if (n_rows_c > 32'(GRID_DIM)) begin
            n_rows_c = 32'(GRID_DIM);
        end
    end

    assign n_inside = (32'(r_viewer_x[21:16]) < n_cols_c) &&
                      (32'(r_viewer_y[21:16]) < n_rows_c);

    // map store
    assign n_wr_en   = n_accept && (i_operation == grc_pkg::OP_WRITE) &&
                       (32'(i_cell_col) < 32'(GRID_DIM)) && (32'(i_cell_row) < 32'(GRID_DIM));
    assign n_wr_addr = AW'(32'(i_cell_row) * 32'(GRID_DIM) + 32'(i_cell_col));

    grc_ram #(
        .WIDTH (8),
        .DEPTH (GRID_DIM * GRID_DIM)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr_en),
        .i_wr_addr (n_wr_addr),
        .i_wr_data (i_cell_kind),
        .i_rd_addr (n_rd_addr),
        .o_rd_data (n_rd_data)
    );

    // direction unit
    assign n_cordic_start = n_accept && (i_operation == grc_pkg::OP_CAST) && n_inside;

    grc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_cordic_start),
        .i_phase ({n_ang[13:0], 16'd0}),
        .o_done  (n_cordic_done),
        .o_cos   (n_cos),
        .o_sin   (n_sin)
    );

    // rotate into the quadrant
    always_comb begin
        case (r_quad)
            2'd0: begin
                n_dx = DW'(n_cos);
                n_dy = DW'(n_sin);
            end
            2'd1: begin
                n_dx = -DW'(n_sin);
                n_dy = DW'(n_cos);
            end
            2'd2: begin
                n_dx = -DW'(n_cos);
                n_dy = -DW'(n_sin);
            end
            default: begin
                n_dx = DW'(n_sin);
                n_dy = -DW'(n_cos);
            end
        endcase
    end

    // step length divider, shared by both axes
    assign n_div_start = ((r_state == S_CORDIC) && n_cordic_done) ||
                         ((r_state == S_DIVX) && n_div_done);
    assign n_div_in    = (r_state == S_CORDIC) ? mag(n_dx) : mag(r_dy);

    grc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (n_div_start),
        .i_divisor (n_div_in),
        .o_done    (n_div_done),
        .o_quot    (n_div_q)
    );

    // shared multiplier: first side distances, then the wall offset
    always_comb begin
        n_d0    = '0;
        n_mul_a = '0;
        n_mul_b = '0;
        case (r_state)
            S_MULX: begin
                n_d0    = (r_dx < 0) ? {1'b0, r_viewer_x[15:0]} :
                                       17'd65536 - {1'b0, r_viewer_x[15:0]};
                n_mul_a = signed'({2'b00, r_lx});
                n_mul_b = signed'({1'b0, n_d0});
            end
            S_MULY: begin
                n_d0    = (r_dy < 0) ? {1'b0, r_viewer_y[15:0]} :
                                       17'd65536 - {1'b0, r_viewer_y[15:0]};
                n_mul_a = signed'({2'b00, r_ly});
                n_mul_b = signed'({1'b0, n_d0});
            end
            default: begin
                n_mul_a = signed'({2'b00, r_perp});
                n_mul_b = r_side ? r_dx : r_dy;
            end
        endcase
    end

    assign n_prod = 52'(n_mul_a) * 52'(n_mul_b);

    // cell walk: cross the nearer grid line, y on a tie
    assign n_take_x  = (r_dx != 0) && ((r_dy == 0) || (r_sx < r_sy));
    assign n_mx      = n_take_x ? r_mx + ((r_dx < 0) ? -MW'(1) : MW'(1)) : r_mx;
    assign n_my      = n_take_x ? r_my : r_my + ((r_dy < 0) ? -MW'(1) : MW'(1));
    assign n_out_map = (n_mx < 0) || (n_mx >= r_cols) || (n_my < 0) || (n_my >= r_rows);
    assign n_rd_addr = AW'(32'(unsigned'(n_my)) * 32'(GRID_DIM) + 32'(unsigned'(n_mx)));

    assign n_load_out = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (n_accept && (i_operation == grc_pkg::OP_CAST)) begin
                        r_state <= n_inside ? S_CORDIC : S_FINISH;
                    end
                end
                S_CORDIC: if (n_cordic_done) r_state <= S_DIVX;
                S_DIVX:   if (n_div_done) r_state <= S_DIVY;
                S_DIVY:   if (n_div_done) r_state <= S_MULX;
                S_MULX:   r_state <= S_MULY;
                S_MULY:   r_state <= S_STEP;
                S_STEP:   r_state <= n_out_map ? S_OFFS : S_READ;
                S_READ:   r_state <= (n_rd_data != 8'd0) ? S_OFFS : S_STEP;
                S_OFFS:   r_state <= S_FINISH;
                S_FINISH: if (n_load_out) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // cast datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_quad   <= n_ang[15:14];
                r_mx     <= MW'(r_viewer_x[21:16]);
                r_my     <= MW'(r_viewer_y[21:16]);
                r_cols   <= MW'(n_cols_c);
                r_rows   <= MW'(n_rows_c);
                r_last_x <= r_viewer_x[21:16];
                r_last_y <= r_viewer_y[21:16];
                r_hit    <= 1'b0;
                r_side   <= 1'b0;
                r_wk     <= '0;
                r_perp   <= '0;
                r_offs   <= '0;
            end
            S_CORDIC: begin
                r_dx <= n_dx;
                r_dy <= n_dy;
            end
            S_DIVX: if (n_div_done) r_lx <= n_div_q;
            S_DIVY: if (n_div_done) r_ly <= n_div_q;
            S_MULX: r_sx <= (r_dx == 0) ? SW'(grc_pkg::SAT32) : SW'(n_prod[48:16]);
            S_MULY: r_sy <= (r_dy == 0) ? SW'(grc_pkg::SAT32) : SW'(n_prod[48:16]);
            S_STEP: begin
                // record the distance before the step, saturated
                if (n_take_x) begin
                    r_perp <= (r_sx > SW'(grc_pkg::SAT32)) ? grc_pkg::SAT32 : r_sx[31:0];
                    r_sx   <= r_sx + SW'(r_lx);
                    r_side <= 1'b0;
                end else begin
                    r_perp <= (r_sy > SW'(grc_pkg::SAT32)) ? grc_pkg::SAT32 : r_sy[31:0];
                    r_sy   <= r_sy + SW'(r_ly);
                    r_side <= 1'b1;
                end
                r_mx <= n_mx;
                r_my <= n_my;
                if (!n_out_map) begin
                    r_last_x <= CW'(unsigned'(n_mx));
                    r_last_y <= CW'(unsigned'(n_my));
                end
            end
            S_READ: begin
                if (n_rd_data != 8'd0) begin
                    r_hit <= 1'b1;
                    r_wk  <= n_rd_data;
                end
            end
            S_OFFS: begin
                r_offs <= (r_side ? r_viewer_x[15:0] : r_viewer_y[15:0]) + n_prod[31:16];
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load_out) begin
            r_out_hit  <= r_hit;
            r_out_side <= r_side;
            r_out_wk   <= r_wk;
            r_out_col  <= r_last_x;
            r_out_row  <= r_last_y;
            r_out_perp <= r_perp;
            r_out_offs <= r_offs;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_hit_side      = r_out_side;
    assign o_wall_kind     = r_out_wk;
    assign o_hit_col       = r_out_col;
    assign o_hit_row       = r_out_row;
    assign o_perp_distance = r_out_perp;
    assign o_wall_offset   = r_out_offs;

endmodule
`default_nettype wire
